### sv/joystick_report_decoder_deadzone_macros.svh
// Assertion macros used by the joystick report decoder checker.
`ifndef JOYSTICK_REPORT_DECODER_DEADZONE_MACROS_SVH
`define JOYSTICK_REPORT_DECODER_DEADZONE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define JRDD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define JRDD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/jrdd_pkg.sv
// Shared types and constants of the joystick report decoder.
package jrdd_pkg;

   localparam int unsigned DZ_WIDTH = 15;
   localparam logic [DZ_WIDTH-1:0] DEAD_ZONE_RESET = 15'd1638;

   localparam logic [1:0] AXIS_LAST = 2'd2;
   localparam logic [3:0] DIV_LAST  = 4'd15;

   typedef struct packed {
      logic       capture;
      logic       prep;
      logic       setup;
      logic       div_step;
      logic       finish;
      logic       publish;
      logic [1:0] axis_sel;
   } cmd_type;

   typedef struct packed {
      logic special;
   } status_type;

endpackage

### sv/joystick_report_decoder_deadzone.sv
// Top level of the joystick report decoder with center calibration and dead zone.
//
// Usage: one joystick report enters on the req_ channel and one decoded result
// leaves on the rsp_ channel. A transfer happens at a rising edge where valid is
// high and stall is low. The dead-zone half-width (Q1.15) is written through
// csr_write_enable/csr_write_data; the user must write it only while the block
// is idle, which the block itself does not enforce. It resets to 1638. Each
// stick axis passes through a shared restoring divider that resolves one
// quotient bit per cycle. An axis takes an early exit when it falls inside the
// dead zone or saturates, and otherwise runs the 16 divide steps. The block
// works on one report at a time. The result sits in an output register, so the
// next request is accepted while a stalled result still waits; the block holds
// req_stall high until its own working result can move into that register. The
// first report after reset stores its centered axes as the per-axis center
// offsets. Synchronous reset clears the calibration and the output valid and
// returns the dead zone to 1638.
module joystick_report_decoder_deadzone
   import jrdd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_stick_bytes,
   input  logic [31:0]         req_lever_bytes,
   input  logic [15:0]         req_button_bytes,
   input  logic [7:0]          req_scroll_byte,
   input  logic [7:0]          req_mouse_byte,
   input  logic                csr_write_enable,
   input  logic [DZ_WIDTH-1:0] csr_write_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_axis_x,
   output logic signed [15:0]  rsp_axis_y,
   output logic signed [15:0]  rsp_axis_z,
   output logic [15:0]         rsp_throttle,
   output logic [15:0]         rsp_rotation_x,
   output logic [15:0]         rsp_rotation_y,
   output logic [15:0]         rsp_slider,
   output logic [15:0]         rsp_buttons,
   output logic signed [1:0]   rsp_scroll,
   output logic                rsp_right_click
);

   cmd_type    cmd;
   status_type status;

   // The controller sequences capture, per-axis setup, divide steps and the
   // final move into the output register.
   jrdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the offsets, the working axis values and the divider.
   jrdd_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_stick_bytes  (req_stick_bytes),
      .req_lever_bytes  (req_lever_bytes),
      .req_button_bytes (req_button_bytes),
      .req_scroll_byte  (req_scroll_byte),
      .req_mouse_byte   (req_mouse_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_axis_x       (rsp_axis_x),
      .rsp_axis_y       (rsp_axis_y),
      .rsp_axis_z       (rsp_axis_z),
      .rsp_throttle     (rsp_throttle),
      .rsp_rotation_x   (rsp_rotation_x),
      .rsp_rotation_y   (rsp_rotation_y),
      .rsp_slider       (rsp_slider),
      .rsp_buttons      (rsp_buttons),
      .rsp_scroll       (rsp_scroll),
      .rsp_right_click  (rsp_right_click)
   );

endmodule

### sv/jrdd_ctrl.sv
// Controller state machine of the joystick report decoder.
module jrdd_ctrl
   import jrdd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SETUP,
      ST_DIV,
      ST_FINISH,
      ST_DONE
   } state_type;

   state_type  state_ff;
   logic [1:0] axis_ff;
   logic [3:0] step_ff;
   logic       rsp_valid_ff;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.axis_sel = axis_ff;
      cmd.capture  = (state_ff == ST_IDLE) && req_valid;
      cmd.prep     = (state_ff == ST_PREP);
      cmd.setup    = (state_ff == ST_SETUP);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.finish   = (state_ff == ST_FINISH);
      cmd.publish  = (state_ff == ST_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_PREP;
                  axis_ff  <= '0;
               end
            end
            ST_PREP: begin
               state_ff <= ST_SETUP;
            end
            ST_SETUP: begin
               step_ff <= '0;
               if (!status.special) begin
                  state_ff <= ST_DIV;
               end else if (axis_ff == AXIS_LAST) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_PREP;
                  axis_ff  <= axis_ff + 2'd1;
               end
            end
            ST_DIV: begin
               step_ff <= step_ff + 4'd1;
               if (step_ff == DIV_LAST) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (axis_ff == AXIS_LAST) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_PREP;
                  axis_ff  <= axis_ff + 2'd1;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### sv/jrdd_datapath.sv
// Datapath of the joystick report decoder: calibration, dead zone, serial divider.
module jrdd_datapath
   import jrdd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         req_stick_bytes,
   input  logic [31:0]         req_lever_bytes,
   input  logic [15:0]         req_button_bytes,
   input  logic [7:0]          req_scroll_byte,
   input  logic [7:0]          req_mouse_byte,
   input  logic                csr_write_enable,
   input  logic [DZ_WIDTH-1:0] csr_write_data,
   input  cmd_type             cmd,
   output status_type          status,
   output logic signed [15:0]  rsp_axis_x,
   output logic signed [15:0]  rsp_axis_y,
   output logic signed [15:0]  rsp_axis_z,
   output logic [15:0]         rsp_throttle,
   output logic [15:0]         rsp_rotation_x,
   output logic [15:0]         rsp_rotation_y,
   output logic [15:0]         rsp_slider,
   output logic [15:0]         rsp_buttons,
   output logic signed [1:0]   rsp_scroll,
   output logic                rsp_right_click
);

   // Centers a raw 10-bit axis to Q1.15; the top code saturates below +1.0.
   function automatic logic signed [15:0] center_raw(input logic [9:0] r);
      logic [9:0] d;
      begin
         if (r <= 10'd512) begin
            d = r - 10'd512;
            center_raw = {d, 6'b0};
         end else if (r == 10'd1023) begin
            center_raw = 16'sh7FFF;
         end else begin
            d = r - 10'd511;
            center_raw = {d, 6'b0};
         end
      end
   endfunction

   logic [DZ_WIDTH-1:0] dz_ff;
   logic                cal_ff;
   logic signed [15:0]  c_ff [3];
   logic signed [15:0]  off_ff [3];
   logic signed [15:0]  res_ff [3];
   logic signed [15:0]  cen [3];

   logic [15:0] thr_ff, rotx_ff, roty_ff, sld_ff, btn_ff;
   logic [1:0]  scroll_ff;
   logic        click_ff;

   logic signed [17:0] a_ff, a_in;
   logic               pos_ff;
   logic [16:0]        den_ff;
   logic [16:0]        rem_ff;
   logic [15:0]        qd_ff;

   logic signed [15:0] c_sel, o_sel;
   logic [17:0]        mag;
   logic [16:0]        nmag;
   logic               pos, below, den_pos, sat;
   logic signed [17:0] base, den;
   logic signed [15:0] special_res, fin_res;
   logic [17:0]        rem2, rem_diff;
   logic               ge;
   logic [1:0]         scroll_in;

   assign cen[0] = center_raw(req_stick_bytes[9:0]);
   assign cen[1] = center_raw(req_stick_bytes[19:10]);
   assign cen[2] = center_raw(req_stick_bytes[31:22]);

   assign c_sel = c_ff[cmd.axis_sel];
   assign o_sel = off_ff[cmd.axis_sel];
   assign a_in  = {{2{c_sel[15]}}, c_sel} - {{2{o_sel[15]}}, o_sel};

   // Dead-zone test, denominator and early-out decision for one axis.
   always_comb begin
      mag     = a_ff[17] ? 18'(-a_ff) : 18'(a_ff);
      pos     = !a_ff[17] && (a_ff != '0);
      below   = mag[16:0] < {2'b0, dz_ff};
      nmag    = mag[16:0] - {2'b0, dz_ff};
      base    = 18'sd32768 - $signed({3'b0, dz_ff});
      den     = pos ? base - {{2{o_sel[15]}}, o_sel} : base + {{2{o_sel[15]}}, o_sel};
      den_pos = !den[17] && (den != '0);
      sat     = {1'b0, nmag} >= {den[16:0], 1'b0};
      status.special = below || !den_pos || sat;
      if (below) begin
         special_res = '0;
      end else begin
         special_res = pos ? 16'sh7FFF : 16'sh8000;
      end
   end

   // One restoring division step per cycle.
   assign rem2     = {rem_ff, qd_ff[15]};
   assign ge       = rem2 >= {1'b0, den_ff};
   assign rem_diff = rem2 - {1'b0, den_ff};

   always_comb begin
      if (pos_ff) begin
         fin_res = qd_ff[15] ? 16'sh7FFF : $signed(qd_ff);
      end else begin
         fin_res = (qd_ff > 16'h8000) ? 16'sh8000 : $signed(16'(-qd_ff));
      end
   end

   always_comb begin
      priority if (req_scroll_byte[0]) begin
         scroll_in = 2'b11;
      end else if (req_scroll_byte[1]) begin
         scroll_in = 2'b01;
      end else begin
         scroll_in = 2'b00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff  <= DEAD_ZONE_RESET;
         cal_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            dz_ff <= csr_write_data;
         end
         if (cmd.capture) begin
            cal_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int i = 0; i < 3; i++) begin
            c_ff[i] <= cen[i];
            if (!cal_ff) begin
               off_ff[i] <= cen[i];
            end
         end
         thr_ff    <= {~req_lever_bytes[7:0],   ~req_lever_bytes[7:0]};
         rotx_ff   <= {~req_lever_bytes[15:8],  ~req_lever_bytes[15:8]};
         roty_ff   <= {~req_lever_bytes[23:16], ~req_lever_bytes[23:16]};
         sld_ff    <= {~req_lever_bytes[31:24], ~req_lever_bytes[31:24]};
         btn_ff    <= req_button_bytes;
         scroll_ff <= scroll_in;
         click_ff  <= req_mouse_byte[2];
      end
      if (cmd.prep) begin
         a_ff <= a_in;
      end
      if (cmd.setup) begin
         pos_ff <= pos;
         den_ff <= den[16:0];
         rem_ff <= {1'b0, nmag[16:1]};
         qd_ff  <= {nmag[0], 15'b0};
         if (status.special) begin
            res_ff[cmd.axis_sel] <= special_res;
         end
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? rem_diff[16:0] : rem2[16:0];
         qd_ff  <= {qd_ff[14:0], ge};
      end
      if (cmd.finish) begin
         res_ff[cmd.axis_sel] <= fin_res;
      end
      if (cmd.publish) begin
         rsp_axis_x      <= res_ff[0];
         rsp_axis_y      <= res_ff[1];
         rsp_axis_z      <= res_ff[2];
         rsp_throttle    <= thr_ff;
         rsp_rotation_x  <= rotx_ff;
         rsp_rotation_y  <= roty_ff;
         rsp_slider      <= sld_ff;
         rsp_buttons     <= btn_ff;
         rsp_scroll      <= scroll_ff;
         rsp_right_click <= click_ff;
      end
   end

endmodule

### sv/jrdd_checker.sv
// Port-level checker of the joystick report decoder and its bind.
`include "joystick_report_decoder_deadzone_macros.svh"

module jrdd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_axis_x,
   input logic [15:0] rsp_axis_y,
   input logic [15:0] rsp_axis_z,
   input logic [15:0] rsp_throttle,
   input logic [15:0] rsp_buttons
);

   // A stalled result must stay put.
   `JRDD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_axis_x) && $stable(rsp_axis_y) && $stable(rsp_axis_z) && $stable(rsp_buttons), "stalled result changed")

   // The block works on one report at a time after a request transfer.
   `JRDD_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "request taken while busy")

   // A new result only appears out of a busy cycle.
   `JRDD_ASSERT_SAME(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall), "result without work")

   // Lever outputs are the inverted byte repeated in both halves.
   `JRDD_ASSERT_SAME(a_lever_form, rsp_valid, rsp_throttle[15:8] == rsp_throttle[7:0], "lever scaling wrong")

endmodule

bind joystick_report_decoder_deadzone jrdd_checker u_checker (.*);
